### rtl/selective_repeat_sender_window_top_macros.svh
// Assertion macros for the selective-repeat sender window.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_TOP_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRSW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srsw assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SRSW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srsw assertion failed");

`endif

### rtl/srsw_pkg.sv
// Shared types, codes and widths for the selective-repeat sender window.
// Used by the controller, the datapath and the top level.
package srsw_pkg;

    localparam int OP_W       = 2;
    localparam int ACK_W      = 32;
    localparam int SACK_W     = 32;
    localparam int SEQ_W      = 20;
    localparam int NUM_W      = 21;
    localparam int OFF_W      = 30;
    localparam int STATUS_W   = 2;
    localparam int WL_W       = 6;
    localparam int CNT3_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;
    localparam int ROUTE_W    = 2;

    localparam int DEF_MAX_WINDOW  = 32;
    localparam int DEF_CHUNK_BYTES = 1024;

    localparam logic [NUM_W-1:0]  SEQ_SPACE = 21'h100000;
    localparam logic [CNT3_W-1:0] CNT3_MAX  = 3'd7;

    localparam logic [OP_W-1:0] OP_START   = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_RUN   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABORT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUPACK  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd3;

    localparam logic [WL_W-1:0]   RST_WINDOW  = 6'd32;
    localparam logic [NUM_W-1:0]  RST_CHUNKS  = 21'd1;
    localparam logic [CNT3_W-1:0] RST_DUPACK  = 3'd3;
    localparam logic [CNT3_W-1:0] RST_TIMEOUT = 3'd3;

    localparam logic [ROUTE_W-1:0] ROUTE_MARK  = 2'd0;
    localparam logic [ROUTE_W-1:0] ROUTE_SCAN  = 2'd1;
    localparam logic [ROUTE_W-1:0] ROUTE_FLUSH = 2'd2;

    typedef struct packed {
        logic load;
        logic decode;
        logic mark_step;
        logic shift_step;
        logic setup;
        logic scan_step;
        logic flush;
    } srsw_cmd_t;

    typedef struct packed {
        logic [ROUTE_W-1:0] route;
        logic               is_adv;
        logic               mark_done;
        logic               shift_done;
        logic               scan_done;
        logic               scan_ok;
        logic               out_free;
    } srsw_sts_t;

endpackage

### rtl/srsw_ctrl.sv
// Sequencing state machine for the selective-repeat sender window.
// Depends on srsw_pkg for the command and status structs.
module srsw_ctrl
    import srsw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  srsw_sts_t sts,
    output srsw_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_MARK   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_SETUP  = 3'd4;
    localparam logic [2:0] S_SCAN   = 3'd5;
    localparam logic [2:0] S_FLUSH  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                case (sts.route)
                    ROUTE_MARK: state_next = S_MARK;
                    ROUTE_SCAN: state_next = S_SCAN;
                    default:    state_next = S_FLUSH;
                endcase
            end
            S_MARK:
            begin
                if (sts.mark_done)
                begin
                    state_next = sts.is_adv ? S_SHIFT : S_SCAN;
                end
                else
                begin
                    cmd.mark_step = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (sts.shift_done)
                begin
                    state_next = S_SETUP;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_FLUSH;
                end
                else if (sts.scan_ok)
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/srsw_dp.sv
// Datapath of the selective-repeat sender window: registers, window map,
// walk counters, pending send and output register. Depends on srsw_pkg.
`include "selective_repeat_sender_window_top_macros.svh"

module srsw_dp
    import srsw_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int CHUNK_BYTES = DEF_CHUNK_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [OP_W-1:0]       op,
    input  logic [ACK_W-1:0]      ack_seq,
    input  logic [SACK_W-1:0]     sack_bits,
    input  srsw_cmd_t             cmd,
    output srsw_sts_t             sts,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  send_valid,
    output logic [SEQ_W-1:0]      send_seq,
    output logic [OFF_W-1:0]      send_offset,
    output logic [STATUS_W-1:0]   status,
    output logic                  last
);

    localparam int MW     = MAX_WINDOW;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int CHK_W  = $clog2(CHUNK_BYTES + 1);
    localparam int PROD_W = SEQ_W + CHK_W;

    logic [WL_W-1:0]     wl_reg, wl_next;
    logic [NUM_W-1:0]    tc_reg, tc_next;
    logic [CNT3_W-1:0]   thr_reg, thr_next;
    logic [CNT3_W-1:0]   lim_reg, lim_next;

    logic [OP_W-1:0]     op_reg;
    logic [ACK_W-1:0]    ack_reg;
    logic [SACK_W-1:0]   sack_reg;

    logic [MW-1:0]       acked_reg, acked_next;
    logic [NUM_W-1:0]    base_reg, base_next;
    logic [NUM_W-1:0]    unacked_reg, unacked_next;
    logic [CNT3_W-1:0]   dup_reg, dup_next;
    logic [CNT3_W-1:0]   tmo_reg, tmo_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                active_reg, active_next;
    logic [CNT_W-1:0]    runw_reg, runw_next;
    logic [NUM_W-1:0]    runn_reg, runn_next;

    logic                is_adv_reg, is_adv_next;
    logic [CNT_W-1:0]    mark_cnt_reg, mark_cnt_next;
    logic [NUM_W-1:0]    mark_seq_reg, mark_seq_next;
    logic [MW-1:0]       mark_mask_reg, mark_mask_next;
    logic [SACK_W-1:0]   sack_sh_reg, sack_sh_next;
    logic [CNT_W-1:0]    shift_cnt_reg, shift_cnt_next;
    logic [CNT_W-1:0]    scan_cnt_reg, scan_cnt_next;
    logic [NUM_W-1:0]    scan_seq_reg, scan_seq_next;
    logic [NUM_W-1:0]    scan_hi_reg, scan_hi_next;
    logic [MW-1:0]       scan_map_reg, scan_map_next;
    logic                hold_valid_reg, hold_valid_next;
    logic [SEQ_W-1:0]    hold_seq_reg, hold_seq_next;

    logic                out_valid_reg;
    logic                out_send_reg;
    logic [SEQ_W-1:0]    out_seq_reg;
    logic [OFF_W-1:0]    out_off_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_last_reg;

    logic [CNT_W-1:0]    w_clamp;
    logic [NUM_W-1:0]    n_clamp;
    logic [ACK_W-1:0]    base_ext;
    logic [ACK_W-1:0]    diff;
    logic                is_dup;
    logic                is_fwd;
    logic [CNT3_W-1:0]   dup_inc;
    logic                fire;
    logic [CNT3_W-1:0]   tmo_inc;
    logic [CNT3_W-1:0]   lim_eff;
    logic                abort;
    logic                running;
    logic [NUM_W-1:0]    base_plus_w;
    logic                shift_go;
    logic                pass;
    logic                push;
    logic                out_free;
    logic [SEQ_W-1:0]    push_seq;
    logic [PROD_W-1:0]   prod;

    assign w_clamp = (wl_reg == '0) ? CNT_W'(1) :
                     (wl_reg > WL_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : CNT_W'(wl_reg);
    assign n_clamp = (tc_reg == '0) ? NUM_W'(1) :
                     (tc_reg > SEQ_SPACE) ? SEQ_SPACE : tc_reg;

    assign base_ext    = ACK_W'(base_reg);
    assign diff        = ack_reg - base_ext;
    assign is_dup      = (ack_reg == base_ext);
    assign is_fwd      = (ack_reg > base_ext) && (diff <= ACK_W'(runw_reg))
                         && (ack_reg <= ACK_W'(runn_reg));
    assign dup_inc     = dup_reg + CNT3_W'(1);
    assign fire        = (dup_reg != CNT3_MAX) && (dup_inc == thr_reg) && (base_reg < runn_reg);
    assign tmo_inc     = (tmo_reg == CNT3_MAX) ? CNT3_MAX : tmo_reg + CNT3_W'(1);
    assign lim_eff     = (lim_reg == '0) ? CNT3_W'(1) : lim_reg;
    assign abort       = (tmo_inc >= lim_eff);
    assign running     = active_reg && (status_reg == ST_RUN);
    assign base_plus_w = base_reg + NUM_W'(runw_reg);
    assign shift_go    = (shift_cnt_reg < runw_reg) && acked_reg[0];
    assign pass        = (scan_seq_reg < scan_hi_reg) && !scan_map_reg[0];
    assign out_free    = !out_valid_reg || out_ready;
    assign push        = (cmd.scan_step && pass && hold_valid_reg) || cmd.flush;
    assign push_seq    = hold_valid_reg ? hold_seq_reg : '0;
    assign prod        = PROD_W'(push_seq) * PROD_W'(CHUNK_BYTES);

    always_comb
    begin
        sts.route = ROUTE_FLUSH;
        unique case (op_reg)
            OP_START:
            begin
                sts.route = ROUTE_SCAN;
            end
            OP_ACK:
            begin
                if (running && (is_dup || is_fwd))
                begin
                    sts.route = ROUTE_MARK;
                end
            end
            OP_TIMEOUT:
            begin
                if (running && !abort)
                begin
                    sts.route = ROUTE_SCAN;
                end
            end
            default:
            begin
                sts.route = ROUTE_FLUSH;
            end
        endcase
        sts.is_adv     = is_adv_reg;
        sts.mark_done  = (mark_cnt_reg == '0);
        sts.shift_done = !shift_go;
        sts.scan_done  = (scan_cnt_reg == '0);
        sts.scan_ok    = !(pass && hold_valid_reg) || out_free;
        sts.out_free   = out_free;
    end

    always_comb
    begin
        wl_next         = wl_reg;
        tc_next         = tc_reg;
        thr_next        = thr_reg;
        lim_next        = lim_reg;
        acked_next      = acked_reg;
        base_next       = base_reg;
        unacked_next    = unacked_reg;
        dup_next        = dup_reg;
        tmo_next        = tmo_reg;
        status_next     = status_reg;
        active_next     = active_reg;
        runw_next       = runw_reg;
        runn_next       = runn_reg;
        is_adv_next     = is_adv_reg;
        mark_cnt_next   = mark_cnt_reg;
        mark_seq_next   = mark_seq_reg;
        mark_mask_next  = mark_mask_reg;
        sack_sh_next    = sack_sh_reg;
        shift_cnt_next  = shift_cnt_reg;
        scan_cnt_next   = scan_cnt_reg;
        scan_seq_next   = scan_seq_reg;
        scan_hi_next    = scan_hi_reg;
        scan_map_next   = scan_map_reg;
        hold_valid_next = hold_valid_reg;
        hold_seq_next   = hold_seq_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW:  wl_next  = cfg_data[WL_W-1:0];
                CFG_CHUNKS:  tc_next  = cfg_data[NUM_W-1:0];
                CFG_DUPACK:  thr_next = cfg_data[CNT3_W-1:0];
                CFG_TIMEOUT: lim_next = cfg_data[CNT3_W-1:0];
                default:     wl_next  = wl_reg;
            endcase
        end

        if (cmd.decode)
        begin
            unique case (op_reg)
                OP_START:
                begin
                    runw_next     = w_clamp;
                    runn_next     = n_clamp;
                    acked_next    = '0;
                    base_next     = '0;
                    unacked_next  = n_clamp;
                    dup_next      = '0;
                    tmo_next      = '0;
                    status_next   = ST_RUN;
                    active_next   = 1'b1;
                    scan_seq_next = '0;
                    scan_hi_next  = n_clamp;
                    scan_map_next = '0;
                    scan_cnt_next = w_clamp;
                end
                OP_ACK:
                begin
                    if (running)
                    begin
                        tmo_next = '0;
                        if (is_dup)
                        begin
                            is_adv_next    = 1'b0;
                            sack_sh_next   = sack_reg;
                            mark_seq_next  = base_reg + NUM_W'(1);
                            mark_mask_next = MW'(2);
                            mark_cnt_next  = runw_reg - CNT_W'(1);
                            if (dup_reg != CNT3_MAX)
                            begin
                                dup_next = dup_inc;
                            end
                            scan_seq_next = base_reg;
                            scan_hi_next  = runn_reg;
                            scan_map_next = '0;
                            scan_cnt_next = fire ? CNT_W'(1) : '0;
                        end
                        else if (is_fwd)
                        begin
                            is_adv_next    = 1'b1;
                            dup_next       = '0;
                            sack_sh_next   = '1;
                            mark_seq_next  = base_reg;
                            mark_mask_next = MW'(1);
                            mark_cnt_next  = CNT_W'(diff);
                            shift_cnt_next = '0;
                            scan_seq_next  = base_plus_w;
                        end
                    end
                end
                OP_TIMEOUT:
                begin
                    if (running)
                    begin
                        tmo_next = tmo_inc;
                        if (abort)
                        begin
                            status_next = ST_ABORT;
                        end
                        else
                        begin
                            scan_seq_next = base_reg;
                            scan_hi_next  = runn_reg;
                            scan_map_next = acked_reg;
                            scan_cnt_next = runw_reg;
                        end
                    end
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end

        if (cmd.mark_step)
        begin
            if (sack_sh_reg[0] && (mark_seq_reg < runn_reg) && ((acked_reg & mark_mask_reg) == '0))
            begin
                acked_next = acked_reg | mark_mask_reg;
                if (unacked_reg != '0)
                begin
                    unacked_next = unacked_reg - NUM_W'(1);
                end
            end
            sack_sh_next   = sack_sh_reg >> 1;
            mark_seq_next  = mark_seq_reg + NUM_W'(1);
            mark_mask_next = mark_mask_reg << 1;
            mark_cnt_next  = mark_cnt_reg - CNT_W'(1);
        end

        if (cmd.shift_step)
        begin
            acked_next     = acked_reg >> 1;
            base_next      = base_reg + NUM_W'(1);
            shift_cnt_next = shift_cnt_reg + CNT_W'(1);
        end

        if (cmd.setup)
        begin
            if ((unacked_reg == '0) && (base_reg == runn_reg))
            begin
                status_next   = ST_DONE;
                scan_cnt_next = '0;
            end
            else
            begin
                scan_hi_next  = (base_plus_w < runn_reg) ? base_plus_w : runn_reg;
                scan_map_next = '0;
                scan_cnt_next = runw_reg;
            end
        end

        if (cmd.scan_step)
        begin
            if (pass)
            begin
                hold_valid_next = 1'b1;
                hold_seq_next   = scan_seq_reg[SEQ_W-1:0];
            end
            scan_seq_next = scan_seq_reg + NUM_W'(1);
            scan_map_next = scan_map_reg >> 1;
            scan_cnt_next = scan_cnt_reg - CNT_W'(1);
        end

        if (cmd.flush)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg         <= RST_WINDOW;
            tc_reg         <= RST_CHUNKS;
            thr_reg        <= RST_DUPACK;
            lim_reg        <= RST_TIMEOUT;
            acked_reg      <= '0;
            base_reg       <= '0;
            unacked_reg    <= '0;
            dup_reg        <= '0;
            tmo_reg        <= '0;
            status_reg     <= ST_RUN;
            active_reg     <= 1'b0;
            runw_reg       <= CNT_W'(1);
            runn_reg       <= NUM_W'(1);
            is_adv_reg     <= 1'b0;
            mark_cnt_reg   <= '0;
            shift_cnt_reg  <= '0;
            scan_cnt_reg   <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            wl_reg         <= wl_next;
            tc_reg         <= tc_next;
            thr_reg        <= thr_next;
            lim_reg        <= lim_next;
            acked_reg      <= acked_next;
            base_reg       <= base_next;
            unacked_reg    <= unacked_next;
            dup_reg        <= dup_next;
            tmo_reg        <= tmo_next;
            status_reg     <= status_next;
            active_reg     <= active_next;
            runw_reg       <= runw_next;
            runn_reg       <= runn_next;
            is_adv_reg     <= is_adv_next;
            mark_cnt_reg   <= mark_cnt_next;
            shift_cnt_reg  <= shift_cnt_next;
            scan_cnt_reg   <= scan_cnt_next;
            hold_valid_reg <= hold_valid_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            ack_reg  <= ack_seq;
            sack_reg <= sack_bits;
        end
        mark_seq_reg  <= mark_seq_next;
        mark_mask_reg <= mark_mask_next;
        sack_sh_reg   <= sack_sh_next;
        scan_seq_reg  <= scan_seq_next;
        scan_hi_reg   <= scan_hi_next;
        scan_map_reg  <= scan_map_next;
        hold_seq_reg  <= hold_seq_next;
        if (push)
        begin
            out_send_reg   <= hold_valid_reg;
            out_seq_reg    <= push_seq;
            out_off_reg    <= hold_valid_reg ? OFF_W'(prod) : '0;
            out_status_reg <= status_reg;
            out_last_reg   <= cmd.flush;
        end
    end

    assign out_valid   = out_valid_reg;
    assign send_valid  = out_send_reg;
    assign send_seq    = out_seq_reg;
    assign send_offset = out_off_reg;
    assign status      = out_status_reg;
    assign last        = out_last_reg;

    `SRSW_ASSERT_IMP(a_no_overwrite, push && out_valid_reg, out_ready)
    `SRSW_ASSERT_NEXT(a_flush_is_last, cmd.flush, out_valid_reg && out_last_reg)
    `SRSW_ASSERT_IMP(a_load_no_pending, cmd.load, !hold_valid_reg)
    `SRSW_ASSERT_IMP(a_final_status_no_send,
        out_valid_reg && (out_status_reg != ST_RUN), !out_send_reg)

endmodule

### rtl/selective_repeat_sender_window_top.sv
// Selective-repeat sender window, one event at a time: the idle state accepts an event, then
// decode; an advancing ACK runs map walk, window slide, setup, send scan and flush, a duplicate
// ACK skips the slide and setup, a start or a timeout goes from decode to the send scan, and any
// other event goes to flush. The send scan and flush wait while the output stalls.
// Reset clears the window state and loads the register defaults; there is no clearing pass.
// Depends on srsw_pkg, srsw_ctrl and srsw_dp.
module selective_repeat_sender_window_top
    import srsw_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int CHUNK_BYTES = DEF_CHUNK_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [OP_W-1:0]       op,
    input  logic [ACK_W-1:0]      ack_seq,
    input  logic [SACK_W-1:0]     sack_bits,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  send_valid,
    output logic [SEQ_W-1:0]      send_seq,
    output logic [OFF_W-1:0]      send_offset,
    output logic [STATUS_W-1:0]   status,
    output logic                  last
);

    srsw_cmd_t cmd;
    srsw_sts_t sts;

    srsw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    srsw_dp
    #(
        .MAX_WINDOW  (MAX_WINDOW),
        .CHUNK_BYTES (CHUNK_BYTES)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .op          (op),
        .ack_seq     (ack_seq),
        .sack_bits   (sack_bits),
        .cmd         (cmd),
        .sts         (sts),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .send_valid  (send_valid),
        .send_seq    (send_seq),
        .send_offset (send_offset),
        .status      (status),
        .last        (last)
    );

endmodule
